@@ src/nnte_pkg.sv @@
// ----------------------------------------------------------------------------
// nnte_pkg
// Shared widths, register indexes and helpers of the negacyclic NTT engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nnte_pkg;

  localparam int CW      = 62;
  localparam int MAX_LEN = 1024;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int LOG_MAX = AW;
  localparam int LW      = $clog2(LOG_MAX + 1);
  localparam int CNTW    = AW + 1;
  localparam int CFG_IW  = 3;
  localparam int BITW    = $clog2(CW);

  typedef logic [CW-1:0] coef_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MODULUS  = 3'd0,
    CFG_ROOT     = 3'd1,
    CFG_ROOT_INV = 3'd2,
    CFG_LEN_INV  = 3'd3,
    CFG_SIZE     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_XFORM = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  function automatic logic [AW-1:0] bit_rev(logic [AW-1:0] x, logic [LW-1:0] bits);
    logic [AW-1:0] r;
    for (int k = 0; k < AW; k++) r[k] = x[AW-1-k];
    return r >> (LW'(LOG_MAX) - bits);
  endfunction

endpackage

`default_nettype wire

@@ src/nnte_mulmod.sv @@
// ----------------------------------------------------------------------------
// nnte_mulmod
// Bit-serial modular multiplier: a * b mod q, MSB first, one double or one
// add step per cycle. Requires a < q. Result held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module nnte_mulmod import nnte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  coef_t a_i,
  input  coef_t b_i,
  input  coef_t q_i,
  output logic  done_o,
  output coef_t res_o
);

  logic            busy_q, busy_d;
  logic            phase_q, phase_d;
  logic            done_q, done_d;
  logic [BITW-1:0] bit_q, bit_d;
  coef_t           r_q, r_d, a_q, a_d, b_q, b_d;
  logic [CW:0]     step;
  coef_t           r_red;

  always_comb begin
    step  = phase_q ? ({1'b0, r_q} + {1'b0, a_q}) : {r_q, 1'b0};
    r_red = (step >= {1'b0, q_i}) ? CW'(step - {1'b0, q_i}) : CW'(step);
  end

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = done_q;
    bit_d   = bit_q;
    r_d     = r_q;
    a_d     = a_q;
    b_d     = b_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      done_d  = 1'b0;
      bit_d   = BITW'(CW - 1);
      r_d     = '0;
      a_d     = a_i;
      b_d     = b_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        r_d     = r_red;
        phase_d = 1'b1;
      end else begin
        if (b_q[CW-1]) r_d = r_red;
        b_d     = b_q << 1;
        phase_d = 1'b0;
        if (bit_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          bit_d = bit_q - BITW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

`default_nettype wire

@@ src/negacyclic_ntt_engine.sv @@
// ----------------------------------------------------------------------------
// negacyclic_ntt_engine
// Holds one polynomial mod q and transforms it in place (negacyclic NTT).
// ----------------------------------------------------------------------------
// Input channel (valid/ready) carries action, slot, coefficient, direction.
// Every input beat yields exactly one output beat (read_value, index_error).
// Config is a plain write port; write only while the block is idle.
// One item is in work at a time; in_ready_o is high only when idle.
// Every modular multiply runs on the single shared nnte_mulmod (62 bits, one
// double or add step per cycle). A write multiplies once to reduce its
// coefficient; a read, a bad slot or an unused action needs no multiply. A
// transform of n points reduces its roots and scale, reduces every entry,
// then twists, permutes and runs the butterflies (forward), or runs the
// butterflies, permutes, then twists and scales (inverse).
// The store is one 1024 x 62 memory, one read and one write port, read data
// registered; read data of an entry written in the same cycle is never used.
// Reset restores the config registers; the store keeps undefined contents.
// A stalled output holds its beat in the output register; the next item may
// be accepted meanwhile and its result waits until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module negacyclic_ntt_engine import nnte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [AW-1:0]     slot_i,
  input  coef_t             coefficient_i,
  input  logic              direction_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output coef_t             read_value_o,
  output logic              index_error_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  coef_t             cfg_data_i
);

  typedef enum logic [30:0] {
    S_IDLE    = 31'(1) << 0,
    S_WR_MUL  = 31'(1) << 1,
    S_WR_ST   = 31'(1) << 2,
    S_RD_WAIT = 31'(1) << 3,
    S_MW      = 31'(1) << 4,
    S_DONE    = 31'(1) << 5,
    S_T_PSI   = 31'(1) << 6,
    S_T_PSIN  = 31'(1) << 7,
    S_T_SCALE = 31'(1) << 8,
    S_T_GO    = 31'(1) << 9,
    S_RED_RD  = 31'(1) << 10,
    S_RED_MUL = 31'(1) << 11,
    S_RED_WR  = 31'(1) << 12,
    S_TW_RD   = 31'(1) << 13,
    S_TW_MUL  = 31'(1) << 14,
    S_TW_SC   = 31'(1) << 15,
    S_TW_WR   = 31'(1) << 16,
    S_TW_T    = 31'(1) << 17,
    S_PM      = 31'(1) << 18,
    S_PM_A    = 31'(1) << 19,
    S_PM_B    = 31'(1) << 20,
    S_PM_C    = 31'(1) << 21,
    S_ST      = 31'(1) << 22,
    S_SQ      = 31'(1) << 23,
    S_SQ_R    = 31'(1) << 24,
    S_BF_RA   = 31'(1) << 25,
    S_BF_RB   = 31'(1) << 26,
    S_BF_C    = 31'(1) << 27,
    S_BF_F    = 31'(1) << 28,
    S_BF_G    = 31'(1) << 29,
    S_BF_W    = 31'(1) << 30
  } state_e;

  function automatic coef_t add_mod(coef_t a, coef_t b, coef_t q);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, q}) ? CW'(s - {1'b0, q}) : CW'(s);
  endfunction

  function automatic coef_t sub_mod(coef_t a, coef_t b, coef_t q);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, q} - {1'b0, b};
    return (a >= b) ? (a - b) : CW'(s);
  endfunction

  // config
  coef_t         modulus_q, root_q, root_inv_q, len_inv_q;
  logic [3:0]    size_q;

  state_e        state_q, state_d, ret_q, ret_d;
  logic          ov_q, ov_d;
  coef_t         rv_q, rv_d;
  logic          err_q, err_d;

  logic [CNTW-1:0] cnt_q, cnt_d, blk_q, blk_d;
  logic [AW-1:0]   j_q, j_d, slot_q, slot_d;
  logic [LW-1:0]   s_q, s_d, k_q, k_d;
  coef_t           w_q, w_d, wl_q, wl_d, t_q, t_d, psi_q, psi_d, psin_q, psin_d;
  coef_t           scale_q, scale_d, u_q, u_d, v_q, v_d, coef_q, coef_d, res_val_q, res_val_d;
  logic            res_err_q, res_err_d, dir_q, dir_d;

  coef_t           coef_mem [MAX_LEN];
  coef_t           rd_data_q;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  coef_t           wr_data;

  logic            mul_start, mul_done;
  coef_t           mul_a, mul_b, mul_res;

  coef_t           q_eff, aone, root_sel;
  logic [LW-1:0]   bits_c;
  logic [CNTW-1:0] n_c, len_c;
  logic [AW-1:0]   h_c, idx0, idx1, rev_c;
  logic            load;

  always_comb begin
    q_eff    = (modulus_q < CW'(2)) ? CW'(1) : modulus_q;
    aone     = {{(CW-1){1'b0}}, (modulus_q >= CW'(2))};
    bits_c   = (size_q == '0) ? LW'(1) :
               ((size_q > LW'(LOG_MAX)) ? LW'(LOG_MAX) : size_q);
    n_c      = CNTW'(1) << bits_c;
    len_c    = CNTW'(1) << s_q;
    h_c      = AW'(1) << (s_q - LW'(1));
    idx0     = blk_q[AW-1:0] + j_q;
    idx1     = idx0 + h_c;
    rev_c    = bit_rev(cnt_q[AW-1:0], bits_c);
    root_sel = dir_q ? psin_q : psi_q;
    load     = (state_q == S_DONE) && (!ov_q || out_ready_i);
  end

  nnte_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .q_i    (q_eff),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cnt_d     = cnt_q;
    blk_d     = blk_q;
    j_d       = j_q;
    s_d       = s_q;
    k_d       = k_q;
    w_d       = w_q;
    wl_d      = wl_q;
    t_d       = t_q;
    psi_d     = psi_q;
    psin_d    = psin_q;
    scale_d   = scale_q;
    u_d       = u_q;
    v_d       = v_q;
    slot_d    = slot_q;
    coef_d    = coef_q;
    dir_d     = dir_q;
    res_val_d = res_val_q;
    res_err_d = res_err_q;
    mul_start = 1'b0;
    mul_a     = aone;
    mul_b     = '0;
    rd_addr   = cnt_q[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cnt_q[AW-1:0];
    wr_data   = mul_res;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          slot_d    = slot_i;
          coef_d    = coefficient_i;
          dir_d     = direction_i;
          res_val_d = '0;
          res_err_d = 1'b0;
          rd_addr   = slot_i;
          case (action_e'(action_i))
            ACT_WRITE, ACT_READ: begin
              if ({1'b0, slot_i} >= n_c) begin
                res_err_d = 1'b1;
                state_d   = S_DONE;
              end else if (action_e'(action_i) == ACT_WRITE) begin
                state_d = S_WR_MUL;
              end else begin
                state_d = S_RD_WAIT;
              end
            end
            ACT_XFORM: state_d = S_T_PSI;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_WR_MUL: begin
        mul_start = 1'b1;
        mul_b     = coef_q;
        ret_d     = S_WR_ST;
        state_d   = S_MW;
      end
      S_WR_ST: begin
        wr_en   = 1'b1;
        wr_addr = slot_q;
        state_d = S_DONE;
      end
      S_RD_WAIT: begin
        res_val_d = rd_data_q;
        state_d   = S_DONE;
      end
      S_MW: begin
        if (mul_done) state_d = ret_q;
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      S_T_PSI: begin
        mul_start = 1'b1;
        mul_b     = root_q;
        ret_d     = S_T_PSIN;
        state_d   = S_MW;
      end
      S_T_PSIN: begin
        psi_d     = mul_res;
        mul_start = 1'b1;
        mul_b     = root_inv_q;
        ret_d     = S_T_SCALE;
        state_d   = S_MW;
      end
      S_T_SCALE: begin
        psin_d    = mul_res;
        mul_start = 1'b1;
        mul_b     = len_inv_q;
        ret_d     = S_T_GO;
        state_d   = S_MW;
      end
      S_T_GO: begin
        scale_d = mul_res;
        cnt_d   = '0;
        state_d = S_RED_RD;
      end
      S_RED_RD: begin
        if (cnt_q == n_c) begin
          cnt_d = '0;
          t_d   = aone;
          if (dir_q) begin
            s_d     = bits_c;
            state_d = S_ST;
          end else begin
            state_d = S_TW_RD;
          end
        end else begin
          state_d = S_RED_MUL;
        end
      end
      S_RED_MUL: begin
        mul_start = 1'b1;
        mul_b     = rd_data_q;
        ret_d     = S_RED_WR;
        state_d   = S_MW;
      end
      S_RED_WR: begin
        wr_en   = 1'b1;
        cnt_d   = cnt_q + CNTW'(1);
        state_d = S_RED_RD;
      end
      S_TW_RD: begin
        if (cnt_q == n_c) begin
          cnt_d   = '0;
          state_d = dir_q ? S_DONE : S_PM;
        end else begin
          state_d = S_TW_MUL;
        end
      end
      S_TW_MUL: begin
        mul_start = 1'b1;
        mul_a     = rd_data_q;
        mul_b     = t_q;
        ret_d     = S_TW_SC;
        state_d   = S_MW;
      end
      S_TW_SC: begin
        if (dir_q) begin
          mul_start = 1'b1;
          mul_a     = mul_res;
          mul_b     = scale_q;
          ret_d     = S_TW_WR;
          state_d   = S_MW;
        end else begin
          state_d = S_TW_WR;
        end
      end
      S_TW_WR: begin
        wr_en     = 1'b1;
        mul_start = 1'b1;
        mul_a     = t_q;
        mul_b     = root_sel;
        ret_d     = S_TW_T;
        state_d   = S_MW;
      end
      S_TW_T: begin
        t_d     = mul_res;
        cnt_d   = cnt_q + CNTW'(1);
        state_d = S_TW_RD;
      end
      S_PM: begin
        if (cnt_q == n_c) begin
          cnt_d = '0;
          if (dir_q) begin
            t_d     = aone;
            state_d = S_TW_RD;
          end else begin
            s_d     = LW'(1);
            state_d = S_ST;
          end
        end else if (cnt_q[AW-1:0] < rev_c) begin
          state_d = S_PM_A;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
        end
      end
      S_PM_A: begin
        u_d     = rd_data_q;
        rd_addr = rev_c;
        state_d = S_PM_B;
      end
      S_PM_B: begin
        wr_en   = 1'b1;
        wr_data = rd_data_q;
        state_d = S_PM_C;
      end
      S_PM_C: begin
        wr_en   = 1'b1;
        wr_addr = rev_c;
        wr_data = u_q;
        cnt_d   = cnt_q + CNTW'(1);
        state_d = S_PM;
      end
      S_ST: begin
        wl_d    = root_sel;
        k_d     = bits_c + LW'(1) - s_q;
        state_d = S_SQ;
      end
      S_SQ: begin
        if (k_q == '0) begin
          blk_d   = '0;
          j_d     = '0;
          w_d     = aone;
          state_d = S_BF_RA;
        end else begin
          mul_start = 1'b1;
          mul_a     = wl_q;
          mul_b     = wl_q;
          ret_d     = S_SQ_R;
          state_d   = S_MW;
        end
      end
      S_SQ_R: begin
        wl_d    = mul_res;
        k_d     = k_q - LW'(1);
        state_d = S_SQ;
      end
      S_BF_RA: begin
        rd_addr = idx0;
        state_d = S_BF_RB;
      end
      S_BF_RB: begin
        u_d     = rd_data_q;
        rd_addr = idx1;
        state_d = S_BF_C;
      end
      S_BF_C: begin
        v_d       = rd_data_q;
        mul_start = 1'b1;
        mul_a     = dir_q ? sub_mod(u_q, rd_data_q, q_eff) : rd_data_q;
        mul_b     = w_q;
        ret_d     = S_BF_F;
        state_d   = S_MW;
      end
      S_BF_F: begin
        wr_en   = 1'b1;
        wr_addr = idx0;
        wr_data = dir_q ? add_mod(u_q, v_q, q_eff) : add_mod(u_q, mul_res, q_eff);
        v_d     = dir_q ? mul_res : sub_mod(u_q, mul_res, q_eff);
        state_d = S_BF_G;
      end
      S_BF_G: begin
        wr_en     = 1'b1;
        wr_addr   = idx1;
        wr_data   = v_q;
        mul_start = 1'b1;
        mul_a     = w_q;
        mul_b     = wl_q;
        ret_d     = S_BF_W;
        state_d   = S_MW;
      end
      S_BF_W: begin
        w_d     = mul_res;
        state_d = S_BF_RA;
        if (j_q == h_c - AW'(1)) begin
          j_d   = '0;
          w_d   = aone;
          blk_d = blk_q + len_c;
          if (blk_q + len_c == n_c) begin
            if (!dir_q) begin
              if (s_q == bits_c) begin
                state_d = S_DONE;
              end else begin
                s_d     = s_q + LW'(1);
                state_d = S_ST;
              end
            end else begin
              if (s_q == LW'(1)) begin
                cnt_d   = '0;
                state_d = S_PM;
              end else begin
                s_d     = s_q - LW'(1);
                state_d = S_ST;
              end
            end
          end
        end else begin
          j_d = j_q + AW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d  = load | (ov_q & !out_ready_i);
    rv_d  = load ? res_val_q : rv_q;
    err_d = load ? res_err_q : err_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) coef_mem[wr_addr] <= wr_data;
    rd_data_q <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      ov_q       <= 1'b0;
      modulus_q  <= CW'(12289);
      root_q     <= CW'(1);
      root_inv_q <= CW'(1);
      len_inv_q  <= CW'(1);
      size_q     <= 4'(LOG_MAX);
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MODULUS:  modulus_q  <= cfg_data_i;
          CFG_ROOT:     root_q     <= cfg_data_i;
          CFG_ROOT_INV: root_inv_q <= cfg_data_i;
          CFG_LEN_INV:  len_inv_q  <= cfg_data_i;
          CFG_SIZE:     size_q     <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rv_q      <= rv_d;
    err_q     <= err_d;
    cnt_q     <= cnt_d;
    blk_q     <= blk_d;
    j_q       <= j_d;
    s_q       <= s_d;
    k_q       <= k_d;
    w_q       <= w_d;
    wl_q      <= wl_d;
    t_q       <= t_d;
    psi_q     <= psi_d;
    psin_q    <= psin_d;
    scale_q   <= scale_d;
    u_q       <= u_d;
    v_q       <= v_d;
    slot_q    <= slot_d;
    coef_q    <= coef_d;
    dir_q     <= dir_d;
    res_val_q <= res_val_d;
    res_err_q <= res_err_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ov_q;
  assign read_value_o  = rv_q;
  assign index_error_o = err_q;

endmodule

`default_nettype wire

@@ src/nnte_checker.sv @@
// ----------------------------------------------------------------------------
// nnte_checker
// Port-level checks of the negacyclic NTT engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nnte_checker import nnte_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input coef_t             read_value_o,
  input logic              index_error_o
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else         pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(index_error_o))
    else $error("output beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> read_value_o == '0)
    else $error("index error with nonzero read value");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready right after an accepted beat");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("output beat without a pending input beat");

endmodule

bind negacyclic_ntt_engine nnte_checker u_nnte_checker (.*);

`default_nettype wire

@@ verif/tb_negacyclic_ntt_engine.sv @@
// ----------------------------------------------------------------------------
// tb_negacyclic_ntt_engine
// Self-checking bench for the negacyclic NTT engine. A behavioral model of the
// coefficient store predicts every output beat: writes, reads, index errors,
// forward and inverse transforms. Runs directed cases, register extremes and
// random traffic under several sender and receiver throttling modes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_negacyclic_ntt_engine;
  import nnte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned SETTLE      = 8;

  typedef struct {
    coef_t value;
    logic  err;
  } beat_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i      = ACT_NONE;
  logic [AW-1:0]     slot_i        = '0;
  coef_t             coefficient_i = '0;
  logic              direction_i   = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  coef_t             read_value_o;
  logic              index_error_o;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i     = CFG_MODULUS;
  coef_t             cfg_data_i    = '0;

  negacyclic_ntt_engine dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  bit [63:0] poly_store [MAX_LEN];
  bit        poly_written [MAX_LEN];
  bit [61:0] q_reg    = 62'd12289;
  bit [61:0] psi_reg  = 62'd1;
  bit [61:0] psii_reg = 62'd1;
  bit [61:0] ninv_reg = 62'd1;
  bit [3:0]  lg_reg   = 4'd10;

  beat_t       pending_q[$];
  int unsigned in_beats, out_beats, mismatches, idle_cycles;
  int unsigned n_xforms, n_errs, n_reads, n_writes;
  int          idle_mode;

  function automatic bit [63:0] eff_mod();
    return (q_reg < 2) ? 64'd1 : 64'(q_reg);
  endfunction

  function automatic int unsigned eff_log2();
    int unsigned l;
    l = lg_reg;
    if (l < 1) l = 1;
    if (l > LOG_MAX) l = LOG_MAX;
    return l;
  endfunction

  function automatic int unsigned poly_len();
    return 1 << eff_log2();
  endfunction

  function automatic bit [63:0] m_add(bit [63:0] a, bit [63:0] b, bit [63:0] q);
    bit [63:0] s;
    s = a + b;
    return (s >= q) ? s - q : s;
  endfunction

  function automatic bit [63:0] m_sub(bit [63:0] a, bit [63:0] b, bit [63:0] q);
    return (a >= b) ? a - b : a + (q - b);
  endfunction

  function automatic bit [63:0] m_mul(bit [63:0] a, bit [63:0] b, bit [63:0] q);
    bit [63:0] r;
    r = 0;
    for (int k = 63; k >= 0; k--) begin
      r = m_add(r, r, q);
      if (b[k]) r = m_add(r, a, q);
    end
    return r;
  endfunction

  function automatic bit [63:0] m_pow(bit [63:0] base, bit [63:0] e, bit [63:0] q);
    bit [63:0] r;
    r = 1 % q;
    while (e != 0) begin
      if (e[0]) r = m_mul(r, base, q);
      base = m_mul(base, base, q);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic int unsigned rev_bits(int unsigned x, int unsigned nb);
    int unsigned r;
    r = 0;
    for (int k = 0; k < nb; k++) r = (r << 1) | ((x >> k) & 1);
    return r;
  endfunction

  function automatic void bitrev_permute(int unsigned n, int unsigned nb);
    int unsigned j;
    bit [63:0] t;
    for (int unsigned i = 0; i < n; i++) begin
      j = rev_bits(i, nb);
      if (i < j) begin
        t = poly_store[i];
        poly_store[i] = poly_store[j];
        poly_store[j] = t;
      end
    end
  endfunction

  function automatic void ntt_in_place(bit inverse);
    int unsigned nb, n, h;
    bit [63:0] q, psi, psii, scale, tw, wl, w, u, v;
    nb    = eff_log2();
    n     = 1 << nb;
    q     = eff_mod();
    psi   = psi_reg % q;
    psii  = psii_reg % q;
    scale = ninv_reg % q;
    for (int unsigned i = 0; i < n; i++) poly_store[i] = poly_store[i] % q;
    tw = 1 % q;
    if (!inverse) begin
      for (int unsigned i = 0; i < n; i++) begin
        poly_store[i] = m_mul(poly_store[i], tw, q);
        tw = m_mul(tw, psi, q);
      end
      bitrev_permute(n, nb);
      for (int unsigned len = 2; len <= n; len <<= 1) begin
        wl = m_pow(psi, 2 * n / len, q);
        h  = len >> 1;
        for (int unsigned i = 0; i < n; i += len) begin
          w = 1 % q;
          for (int unsigned j = 0; j < h; j++) begin
            u = poly_store[i+j];
            v = m_mul(poly_store[i+j+h], w, q);
            poly_store[i+j]   = m_add(u, v, q);
            poly_store[i+j+h] = m_sub(u, v, q);
            w = m_mul(w, wl, q);
          end
        end
      end
    end else begin
      for (int unsigned len = n; len >= 2; len >>= 1) begin
        wl = m_pow(psii, 2 * n / len, q);
        h  = len >> 1;
        for (int unsigned i = 0; i < n; i += len) begin
          w = 1 % q;
          for (int unsigned j = 0; j < h; j++) begin
            u = poly_store[i+j];
            v = poly_store[i+j+h];
            poly_store[i+j]   = m_add(u, v, q);
            poly_store[i+j+h] = m_mul(m_sub(u, v, q), w, q);
            w = m_mul(w, wl, q);
          end
        end
      end
      bitrev_permute(n, nb);
      for (int unsigned i = 0; i < n; i++) begin
        poly_store[i] = m_mul(m_mul(poly_store[i], tw, q), scale, q);
        tw = m_mul(tw, psii, q);
      end
    end
  endfunction

  function automatic beat_t predict_beat(action_e act, int unsigned slot, bit [61:0] coef,
                                         bit dir);
    beat_t b;
    b.value = '0;
    b.err   = 1'b0;
    case (act)
      ACT_WRITE, ACT_READ: begin
        if (slot >= poly_len()) begin
          b.err = 1'b1;
          n_errs++;
        end else if (act == ACT_WRITE) begin
          poly_store[slot]   = 64'(coef) % eff_mod();
          poly_written[slot] = 1'b1;
          n_writes++;
        end else begin
          b.value = 62'(poly_store[slot]);
          n_reads++;
        end
      end
      ACT_XFORM: begin
        ntt_in_place(dir);
        n_xforms++;
      end
      default: ;
    endcase
    return b;
  endfunction

  function automatic bit [61:0] rand_coef();
    return 62'({$urandom, $urandom});
  endfunction

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_beats <= in_beats + 1;
  end

  // result side: throttling, checking, watchdog
  always @(posedge clk_i) begin
    beat_t exp_b;
    out_ready_i <= !(((idle_mode == 2) && ($urandom_range(99) < 58)) ||
                     ((idle_mode == 3) && ($urandom_range(99) < 35)));
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_beats <= out_beats + 1;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: read_value=%h index_error=%b",
                   read_value_o, index_error_o);
      end else begin
        exp_b = pending_q.pop_front();
        if (read_value_o !== exp_b.value || index_error_o !== exp_b.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on beat %0d: read_value exp %h got %h, index_error exp %b got %b",
                     out_beats, exp_b.value, read_value_o, exp_b.err, index_error_o);
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("tb_negacyclic_ntt_engine: FAIL");
      $finish;
    end
  end

  task automatic send_beat(action_e act, int unsigned slot, bit [61:0] coef, bit dir);
    int unsigned start;
    while (((idle_mode == 1) && ($urandom_range(99) < 58)) ||
           ((idle_mode == 3) && ($urandom_range(99) < 35))) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    slot_i        <= AW'(slot);
    coefficient_i <= coef;
    direction_i   <= dir;
    start = in_beats;
    wait (in_beats != start);
    pending_q.push_back(predict_beat(act, slot, coef, dir));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [61:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODULUS:  q_reg    = val;
      CFG_ROOT:     psi_reg  = val;
      CFG_ROOT_INV: psii_reg = val;
      CFG_LEN_INV:  ninv_reg = val;
      CFG_SIZE:     lg_reg   = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_all(bit [61:0] q, bit [61:0] psi, bit [61:0] psii, bit [61:0] ninv,
                         bit [3:0] lg);
    drain();
    write_reg(CFG_MODULUS, q);
    write_reg(CFG_ROOT, psi);
    write_reg(CFG_ROOT_INV, psii);
    write_reg(CFG_LEN_INV, ninv);
    write_reg(CFG_SIZE, 62'(lg));
  endtask

  function automatic bit all_written();
    for (int unsigned i = 0; i < poly_len(); i++)
      if (!poly_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic fill_poly();
    for (int unsigned i = 0; i < poly_len(); i++) send_beat(ACT_WRITE, i, rand_coef(), 1'b0);
  endtask

  task automatic read_poly();
    for (int unsigned i = 0; i < poly_len(); i++) send_beat(ACT_READ, i, rand_coef(), 1'b0);
  endtask

  // fill, transform, read back: the common use of the block
  task automatic full_round(bit dir);
    fill_poly();
    send_beat(ACT_XFORM, $urandom_range(1023), rand_coef(), dir);
    read_poly();
  endtask

  task automatic test_directed();
    bit [61:0] ones;
    ones = '1;
    send_beat(ACT_WRITE, 0, ones, 1'b0);
    send_beat(ACT_WRITE, 1023, '0, 1'b0);
    send_beat(ACT_READ, 0, '0, 1'b0);
    send_beat(ACT_READ, 1023, ones, 1'b1);
    send_beat(ACT_NONE, 1023, ones, 1'b1);
    set_all(62'd17, 62'd3, 62'd6, 62'd13, 4'd2);
    for (int unsigned i = 0; i < 4; i++) send_beat(ACT_WRITE, i, 62'(i + 15), 1'b0);
    send_beat(ACT_WRITE, 4, 62'd5, 1'b0);
    send_beat(ACT_READ, 1023, '0, 1'b0);
    send_beat(ACT_XFORM, 0, '0, 1'b0);
    read_poly();
    send_beat(ACT_XFORM, 0, '0, 1'b1);
    read_poly();
  endtask

  task automatic test_reg_extremes();
    bit [61:0] ones;
    ones = '1;
    // roots and inverses at or just below q, large modulus, smallest size
    set_all(ones, ones, ones - 1, ones, 4'd1);
    full_round(1'b0);
    full_round(1'b1);
    // stale entries: shrink q, read raw, then transform reduces
    set_all(62'd257, ones, ones, ones, 4'd0);
    read_poly();
    send_beat(ACT_XFORM, 0, '0, 1'b0);
    read_poly();
    set_all(62'd0, 62'd5, 62'd7, 62'd9, 4'd3);
    full_round(1'b0);
    set_all(62'd1, 62'd5, 62'd7, 62'd9, 4'd2);
    full_round(1'b1);
    set_all(62'd2, 62'd1, 62'd1, 62'd1, 4'd1);
    full_round(1'b0);
    set_all(62'd12289, 62'd7, 62'd8778, 62'd11, 4'd15);
    for (int k = 0; k < 12; k++) send_beat(ACT_WRITE, $urandom_range(1023), rand_coef(), 1'b0);
    send_beat(ACT_WRITE, 1023, ones, 1'b0);
    send_beat(ACT_READ, 1023, '0, 1'b0);
  endtask

  task automatic random_config();
    bit [61:0] q;
    case ($urandom_range(5))
      0: q = 62'd12289;
      1: q = 62'd7681;
      2: q = 62'd17;
      3: q = rand_coef();
      4: q = 62'($urandom_range(300));
      default: q = 62'h3FFF_FFFF_FFFF_FFC1;
    endcase
    set_all(q, ($urandom_range(3) == 0) ? rand_coef() : 62'(64'(rand_coef()) % (q + 1)),
            rand_coef(), rand_coef(),
            ($urandom_range(5) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4)));
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned sent, n, r, s;
    random_config();
    sent = 0;
    while (sent < n_items) begin
      n = poly_len();
      r = $urandom_range(99);
      if (n <= 16 && r < 12) begin
        full_round($urandom_range(1));
        sent += 2 * n + 1;
      end else if (r < 15) begin
        send_beat(ACT_NONE, $urandom_range(1023), rand_coef(), $urandom_range(1));
      end else if (r < 22 && n < MAX_LEN) begin
        send_beat($urandom_range(1) ? ACT_WRITE : ACT_READ, $urandom_range(1023, n),
                  rand_coef(), $urandom_range(1));
        sent++;
      end else if (r < 55) begin
        send_beat(ACT_WRITE, $urandom_range(n - 1), rand_coef(), $urandom_range(1));
        sent++;
      end else if (r < 93 || n > 16 || !all_written()) begin
        s = $urandom_range(n - 1);
        if (poly_written[s]) send_beat(ACT_READ, s, rand_coef(), $urandom_range(1));
        else send_beat(ACT_WRITE, s, rand_coef(), $urandom_range(1));
        sent++;
      end else begin
        send_beat(ACT_XFORM, $urandom_range(1023), rand_coef(), $urandom_range(1));
        sent++;
      end
    end
  endtask

  initial begin
    idle_mode = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reg_extremes();
    for (int m = 0; m < 4; m++) begin
      drain();
      idle_mode = m;
      for (int p = 0; p < 3; p++) test_random(140);
    end
    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d input beats: %0d writes, %0d reads, %0d transforms, %0d index errors",
             in_beats, n_writes, n_reads, n_xforms, n_errs);
    $display("checked %0d output beats, %0d mismatches", out_beats, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb_negacyclic_ntt_engine: PASS");
    end else begin
      $display("tb_negacyclic_ntt_engine: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ negacyclic_ntt_engine.f @@
src/nnte_pkg.sv
src/nnte_mulmod.sv
src/negacyclic_ntt_engine.sv
src/nnte_checker.sv
verif/tb_negacyclic_ntt_engine.sv
